[rtl/assert_macros.svh]
// Assertion macros used by the checker file fcw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define FCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcw property violated");

// Next-cycle implication, gated off while reset is asserted.
`define FCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcw property violated");

`endif

[rtl/fcw_pkg.sv]
// Package: types, constants and entry decode functions of the chain walker.
`timescale 1ns / 1ps
package fcw_pkg;

    localparam int ADDR_W  = 13;   // byte_address width
    localparam int CLUS_W  = 16;   // cluster width
    localparam int TB_W    = 14;   // table_bytes width and offset width
    localparam int DIV_W   = 17;   // dividend width for the offset reduction
    localparam int STEP_W  = 5;    // counter for DIV_W remainder steps

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_WALK  = 1'b1;

    localparam logic KIND_FAT12 = 1'b0;
    localparam logic KIND_FAT16 = 1'b1;

    localparam logic REG_FAT_KIND    = 1'b0;
    localparam logic REG_TABLE_BYTES = 1'b1;

    localparam logic [CLUS_W-1:0] END12  = 16'h0FF8;
    localparam logic [CLUS_W-1:0] END16  = 16'hFFF8;
    localparam logic [CLUS_W-1:0] MASK12 = 16'h0FFF;

    localparam logic [TB_W-1:0] TABLE_BYTES_RST = 14'd8192;
    localparam logic [TB_W-1:0] TABLE_MIN       = 14'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic            done;
        logic [TB_W-1:0] rem;
    } t_mod_rsp;

    // Byte offset of a cluster's entry before reduction.
    function automatic logic [DIV_W-1:0] f_dividend(input logic kind,
                                                     input logic [CLUS_W-1:0] clus);
        logic [DIV_W-1:0] d;
        if (kind == KIND_FAT12) begin
            d = DIV_W'(clus) + DIV_W'(clus >> 1);
        end else begin
            d = {clus, 1'b0};
        end
        return d;
    endfunction

    // Decode an entry from its two table bytes.
    function automatic logic [CLUS_W-1:0] f_entry(input logic kind, input logic odd,
                                                  input logic [7:0] lo, input logic [7:0] hi);
        logic [CLUS_W-1:0] w;
        w = {hi, lo};
        if (kind == KIND_FAT12) begin
            w = odd ? (w >> 4) : (w & MASK12);
        end
        return w;
    endfunction

    function automatic logic f_is_end(input logic kind, input logic [CLUS_W-1:0] e);
        return (kind == KIND_FAT12) ? (e >= END12) : (e >= END16);
    endfunction

endpackage

[rtl/fcw_if.sv]
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps
interface fcw_in_if;
    import fcw_pkg::*;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [ADDR_W-1:0]   byte_address;
    logic [7:0]          byte_value;
    logic [CLUS_W-1:0]   start_cluster;

    modport source (output valid, cmd, byte_address, byte_value, start_cluster,
                    input ready);
    modport sink   (input valid, cmd, byte_address, byte_value, start_cluster,
                    output ready);
endinterface

interface fcw_out_if;
    import fcw_pkg::*;
    logic                valid;
    logic                ready;
    logic [CLUS_W-1:0]   cluster;
    logic                last;
    logic                truncated;

    modport source (output valid, cluster, last, truncated, input ready);
    modport sink   (input valid, cluster, last, truncated, output ready);
endinterface

interface fcw_cfg_if;
    import fcw_pkg::*;
    logic                valid;
    logic                ready;
    logic                index;
    logic [TB_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/fat_cluster_chain_walker.sv]
// Top level: FAT12/FAT16 cluster chain walker over a byte-wide table memory.
`timescale 1ns / 1ps
// The block holds a FAT table of FAT_BYTES bytes in a single-port-read,
// single-port-write RAM; its contents are undefined until written, and a walk
// must only touch bytes that were loaded. A write item (cmd 0) stores one byte
// and gives no beat; addresses at or above FAT_BYTES are dropped.
// A walk item (cmd 1) emits start_cluster, then every next cluster read from
// the table, until an end entry (>= 0xFF8 for FAT12, >= 0xFFF8 for FAT16) or
// MAX_CHAIN beats; on a capped walk the final beat carries truncated.
// Entry offsets are cluster*1.5 (FAT12) or cluster*2 (FAT16) modulo the
// table size, which is table_bytes clamped to [2, FAT_BYTES]; the second byte
// wraps to 0 at the end of the table.
// Sequence: each cluster passes through the bit-serial remainder unit (17
// dividend bits, one per cycle, then its done flag), the two pipelined RAM
// reads (address, low byte, high byte), and a decode that loads the output
// register; a stalled output holds the walk in its emit state. The input
// stays not-ready until the final beat sits in the output register.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module fat_cluster_chain_walker #(
    parameter int FAT_BYTES = 8192,
    parameter int MAX_CHAIN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcw_in_if.sink        i_in,
    fcw_out_if.source     o_out,
    fcw_cfg_if.sink       i_cfg
);
    import fcw_pkg::*;

    localparam int AW = $clog2(FAT_BYTES);
    localparam int MW = (AW > TB_W) ? AW : TB_W;
    localparam int CW = $clog2(MAX_CHAIN + 1);
    // only used when table_bytes exceeds FAT_BYTES, so FAT_BYTES fits then
    localparam logic [TB_W-1:0] SIZE_CAP = (FAT_BYTES > 16383) ? 14'd16383
                                                              : TB_W'(FAT_BYTES);

    // configuration
    logic              r_fat_kind;
    logic [TB_W-1:0]   r_table_bytes;

    // walk control
    t_state            r_state, n_state;
    logic [CLUS_W-1:0] r_clus, n_clus;
    logic [TB_W-1:0]   r_off, n_off;
    logic [7:0]        r_lo, n_lo;
    logic [7:0]        r_hi, n_hi;
    logic [CW-1:0]     r_count, n_count;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [CLUS_W-1:0] r_out_cluster, n_out_cluster;
    logic              r_out_last, n_out_last;
    logic              r_out_trunc, n_out_trunc;

    // datapath
    logic [TB_W-1:0]   size;
    logic [TB_W-1:0]   off_inc;
    logic [TB_W-1:0]   off2;
    logic [TB_W-1:0]   rd_off;
    logic [MW-1:0]     rd_ext;
    logic [MW-1:0]     wr_ext;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic              in_acc;
    logic [CLUS_W-1:0] entry;
    logic              is_end;
    logic [CW-1:0]     cnt_inc;
    logic              trunc;
    logic              out_free;
    logic              mod_start;
    logic [CLUS_W-1:0] mod_clus;
    t_mod_rsp          mod_rsp;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fat_kind    <= KIND_FAT12;
            r_table_bytes <= TABLE_BYTES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FAT_KIND:    r_fat_kind    <= i_cfg.data[0];
                REG_TABLE_BYTES: r_table_bytes <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // table size in use, clamped to [2, FAT_BYTES]
    always_comb begin
        if (r_table_bytes < TABLE_MIN) begin
            size = TABLE_MIN;
        end else if (32'(r_table_bytes) > FAT_BYTES) begin
            size = SIZE_CAP;
        end else begin
            size = r_table_bytes;
        end
    end

    // second byte wraps to the start of the table
    assign off_inc = r_off + TB_W'(1);
    assign off2    = (off_inc == size) ? '0 : off_inc;

    // ---------------- table memory ----------------
    assign in_acc = i_in.valid && i_in.ready;
    assign wr_en  = in_acc && (i_in.cmd == CMD_WRITE)
                    && (32'(i_in.byte_address) < FAT_BYTES);
    assign rd_off = (r_state == ST_RD1) ? off2 : r_off;
    assign rd_ext = MW'(rd_off);
    assign wr_ext = MW'(i_in.byte_address);

    fcw_table_ram #(
        .DEPTH (FAT_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_ext[AW-1:0]),
        .i_wdata (i_in.byte_value),
        .i_raddr (rd_ext[AW-1:0]),
        .o_rdata (rd_data)
    );

    // ---------------- offset reduction ----------------
    fcw_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (f_dividend(r_fat_kind, mod_clus)),
        .i_divisor  (size),
        .o_rsp      (mod_rsp)
    );

    // ---------------- entry decode ----------------
    assign entry    = f_entry(r_fat_kind, r_clus[0], r_lo, r_hi);
    assign is_end   = f_is_end(r_fat_kind, entry);
    assign cnt_inc  = r_count + CW'(1);
    assign trunc    = !is_end && (cnt_inc >= CW'(MAX_CHAIN));
    assign out_free = !r_out_valid || o_out.ready;

    // ---------------- walk sequencer ----------------
    always_comb begin
        n_state       = r_state;
        n_clus        = r_clus;
        n_off         = r_off;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_count       = r_count;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_cluster = r_out_cluster;
        n_out_last    = r_out_last;
        n_out_trunc   = r_out_trunc;
        mod_start     = 1'b0;
        mod_clus      = i_in.start_cluster;
        i_in.ready    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid && (i_in.cmd == CMD_WALK)) begin
                    n_clus    = i_in.start_cluster;
                    n_count   = '0;
                    mod_start = 1'b1;
                    n_state   = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_rsp.done) begin
                    n_off   = mod_rsp.rem;
                    n_state = ST_RD0;
                end
            end
            ST_RD0: begin
                // low byte address presented this cycle
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_lo    = rd_data;
                n_state = ST_RD2;
            end
            ST_RD2: begin
                n_hi    = rd_data;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                mod_clus = entry;
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_cluster = r_clus;
                    n_out_last    = is_end || trunc;
                    n_out_trunc   = trunc;
                    n_count       = cnt_inc;
                    if (is_end || trunc) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_clus    = entry;
                        mod_start = 1'b1;
                        n_state   = ST_MOD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clus        <= n_clus;
        r_off         <= n_off;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_out_cluster <= n_out_cluster;
        r_out_last    <= n_out_last;
        r_out_trunc   <= n_out_trunc;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.cluster   = r_out_cluster;
    assign o_out.last      = r_out_last;
    assign o_out.truncated = r_out_trunc;

endmodule

[rtl/fcw_mod_unit.sv]
// Bit-serial remainder unit: dividend modulo table size, one bit per cycle.
`timescale 1ns / 1ps
module fcw_mod_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fcw_pkg::DIV_W-1:0] i_dividend,
    input  logic [fcw_pkg::TB_W-1:0]  i_divisor,
    output fcw_pkg::t_mod_rsp         o_rsp
);
    import fcw_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_dvd, n_dvd;
    logic [TB_W-1:0]   r_dvs, n_dvs;
    logic [TB_W-1:0]   r_rem, n_rem;
    logic [TB_W:0]     trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[DIV_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(DIV_W);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // restoring step: partial remainder stays below the divisor
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = TB_W'(trial - {1'b0, r_dvs});
            end else begin
                n_rem = trial[TB_W-1:0];
            end
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/fcw_table_ram.sv]
// Byte-wide table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module fcw_table_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

[rtl/fcw_checker.sv]
// Port-level checker for the chain walker and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_cluster,
    input logic        i_out_last,
    input logic        i_out_trunc
);
    import fcw_pkg::*;

    // a stalled beat stays offered
    `FCW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // and its cluster does not move
    `FCW_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_cluster))
    // truncation is only flagged on the closing beat of a walk
    `FCW_ASSERT_NOW(a_trunc_last, i_clk, i_rst_n, i_out_valid && i_out_trunc, i_out_last)
    // a walk occupies the block: no new item right after one starts
    `FCW_ASSERT_NEXT(a_walk_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_cmd == CMD_WALK), !i_in_ready)

endmodule

bind fat_cluster_chain_walker fcw_checker u_fcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_cmd      (i_in.cmd),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_cluster (o_out.cluster),
    .i_out_last    (o_out.last),
    .i_out_trunc   (o_out.truncated)
);
